[hw/rtl/lud_pkg.sv]
`default_nettype none

package lud_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned CNT_W  = 2;

  // Each continuation byte carries six payload bits.
  localparam int unsigned CONT_BITS = 6;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Follow-byte counts loaded by the three multi-byte lead forms.
  localparam cnt_t FOLLOW_ONE   = 2'd1;
  localparam cnt_t FOLLOW_TWO   = 2'd2;
  localparam cnt_t FOLLOW_THREE = 2'd3;
  localparam cnt_t FOLLOW_NONE  = 2'd0;

endpackage

`default_nettype wire

[hw/rtl/lud_byte_if.sv]
`default_nettype none

interface lud_byte_if;

  logic           valid;
  logic           ready;
  lud_pkg::byte_t in_byte;
  logic           string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);

endinterface

`default_nettype wire

[hw/rtl/lud_cp_if.sv]
`default_nettype none

interface lud_cp_if;

  logic         valid;
  logic         ready;
  lud_pkg::cp_t code_point;
  logic         last_point;

  modport source (output valid, output code_point, output last_point, input ready);
  modport sink   (input valid, input code_point, input last_point, output ready);

endinterface

`default_nettype wire

[hw/rtl/lenient_utf8_decoder.sv]
`default_nettype none

// Lenient UTF-8 decoder: takes one byte per beat on the stream channel and
// returns decoded code points on the points channel. A byte can be accepted
// in every cycle; each accepted byte gives its result, if any, in the next
// cycle, through the single output register. Stalls on the points side hold
// the input only when that register is full and not being drained. Lead
// bytes 0x80-0xBF and 0xF8-0xFF give U+FFFD, continuation bytes are taken
// without any check (a lead pattern in a continuation slot is just six more
// payload bits), and overlong forms, surrogates and values above U+10FFFF
// pass through unchanged. A byte flagged string_end always gives exactly
// one code point with last_point set; if a sequence is still open at that
// byte, the partial value built so far is returned.
module lenient_utf8_decoder (
  input  wire          clk,
  input  wire          rst,
  lud_byte_if.sink     stream,
  lud_cp_if.source     points
);

  // Classification of a byte seen in lead position.
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_t;

  // Decoder state: partial code point and the continuation bytes still due.
  lud_pkg::cp_t  accumulator;
  lud_pkg::cnt_t bytes_remaining;

  lud_pkg::cp_t  accumulator_next;
  lud_pkg::cnt_t bytes_remaining_next;

  // Output register.
  logic          out_valid;
  lud_pkg::cp_t  out_point;
  logic          out_last;

  logic          emit;
  lud_pkg::cp_t  point_next;
  logic          last_next;

  lead_t         lead;
  lud_pkg::cp_t  shifted;
  logic          accept;

  // The output register frees up either when it is empty or when its beat
  // is taken in this same cycle, so back-to-back bytes never bubble.
  assign stream.ready = !out_valid || points.ready;
  assign accept       = stream.valid && stream.ready;

  assign points.valid      = out_valid;
  assign points.code_point = out_point;
  assign points.last_point = out_last;

  always_comb begin
    if (stream.in_byte inside {[8'h00:8'h7F]}) begin
      lead = LEAD_ASCII;
    end else if (stream.in_byte inside {[8'hC0:8'hDF]}) begin
      lead = LEAD_TWO;
    end else if (stream.in_byte inside {[8'hE0:8'hEF]}) begin
      lead = LEAD_THREE;
    end else if (stream.in_byte inside {[8'hF0:8'hF7]}) begin
      lead = LEAD_FOUR;
    end else begin
      lead = LEAD_BAD;
    end
  end

  // A continuation byte shifts its low six bits in; the top bits fall off
  // the 21-bit accumulator.
  assign shifted = {accumulator[lud_pkg::CP_W-lud_pkg::CONT_BITS-1:0],
                    stream.in_byte[lud_pkg::CONT_BITS-1:0]};

  always_comb begin
    accumulator_next     = accumulator;
    bytes_remaining_next = bytes_remaining;
    emit                 = 1'b0;
    point_next           = accumulator;
    last_next            = stream.string_end;

    if (bytes_remaining == lud_pkg::FOLLOW_NONE) begin
      case (lead)
        LEAD_ASCII: begin
          emit       = 1'b1;
          point_next = {{(lud_pkg::CP_W-lud_pkg::BYTE_W){1'b0}}, stream.in_byte};
        end
        LEAD_TWO: begin
          accumulator_next     = {16'b0, stream.in_byte[4:0]};
          bytes_remaining_next = lud_pkg::FOLLOW_ONE;
        end
        LEAD_THREE: begin
          accumulator_next     = {17'b0, stream.in_byte[3:0]};
          bytes_remaining_next = lud_pkg::FOLLOW_TWO;
        end
        LEAD_FOUR: begin
          accumulator_next     = {18'b0, stream.in_byte[2:0]};
          bytes_remaining_next = lud_pkg::FOLLOW_THREE;
        end
        default: begin
          emit       = 1'b1;
          point_next = lud_pkg::REPLACEMENT;
        end
      endcase
    end else begin
      accumulator_next     = shifted;
      bytes_remaining_next = bytes_remaining - 2'd1;
      if (bytes_remaining == lud_pkg::FOLLOW_ONE) begin
        emit       = 1'b1;
        point_next = shifted;
      end
    end

    // A string that ends inside a sequence returns what has been gathered
    // so far and drops the rest of the sequence.
    if (!emit && stream.string_end) begin
      emit                 = 1'b1;
      point_next           = accumulator_next;
      last_next            = 1'b1;
      bytes_remaining_next = lud_pkg::FOLLOW_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      bytes_remaining <= lud_pkg::FOLLOW_NONE;
    end else if (accept) begin
      accumulator     <= accumulator_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (points.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_point <= point_next;
      out_last  <= last_next;
    end
  end

  // The last byte of a string always produces a flagged code point.
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    accept && stream.string_end |=> points.valid && points.last_point)
    else $error("string end produced no last code point");

  // No sequence stays open across a string boundary.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && stream.string_end |=> bytes_remaining == lud_pkg::FOLLOW_NONE)
    else $error("sequence left open after string end");

  // An ASCII byte in lead position comes out as itself.
  a_ascii_pass: assert property (@(posedge clk) disable iff (rst)
    accept && bytes_remaining == lud_pkg::FOLLOW_NONE && !stream.in_byte[7]
    |=> points.valid
        && points.code_point[lud_pkg::BYTE_W-1:0] == $past(stream.in_byte)
        && points.code_point[lud_pkg::CP_W-1:lud_pkg::BYTE_W] == '0)
    else $error("ASCII byte not passed through");

  // A byte in the middle of a sequence that does not end the string gives
  // no code point.
  a_mid_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !stream.string_end && bytes_remaining != lud_pkg::FOLLOW_NONE
      && bytes_remaining != lud_pkg::FOLLOW_ONE
    |=> !points.valid)
    else $error("code point emitted inside a sequence");

endmodule

`default_nettype wire

[sim/tb_lenient_utf8_decoder.sv]
`default_nettype none

module tb_lenient_utf8_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the decoder state from the accepted bytes and keeps the code points
  // that the block still owes us, oldest first.
  class point_predictor;
    typedef struct packed {
      lud_pkg::cp_t code_point;
      logic         last_point;
    } point_t;

    localparam logic [2:0] TAG_TWO   = 3'b110;
    localparam logic [3:0] TAG_THREE = 4'b1110;
    localparam logic [4:0] TAG_FOUR  = 5'b11110;

    lud_pkg::cp_t  acc;
    lud_pkg::cnt_t remaining;
    point_t        owed[$];
    int            mismatches;

    function new();
      acc        = '0;
      remaining  = lud_pkg::FOLLOW_NONE;
      mismatches = 0;
    endfunction

    function void owe(lud_pkg::cp_t value, logic last);
      point_t entry;
      entry.code_point = value;
      entry.last_point = last;
      owed.insert(owed.size(), entry);
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Note one accepted byte and queue the code point it causes, if any.
    function void take_byte(lud_pkg::byte_t b, logic fin);
      if (remaining == lud_pkg::FOLLOW_NONE) begin
        if (!b[7]) begin
          owe(lud_pkg::cp_t'(b), fin);
          return;
        end else if (b[7:5] == TAG_TWO) begin
          acc       = lud_pkg::cp_t'(b[4:0]);
          remaining = lud_pkg::FOLLOW_ONE;
        end else if (b[7:4] == TAG_THREE) begin
          acc       = lud_pkg::cp_t'(b[3:0]);
          remaining = lud_pkg::FOLLOW_TWO;
        end else if (b[7:3] == TAG_FOUR) begin
          acc       = lud_pkg::cp_t'(b[2:0]);
          remaining = lud_pkg::FOLLOW_THREE;
        end else begin
          owe(lud_pkg::REPLACEMENT, fin);
          return;
        end
      end else begin
        acc       = {acc[lud_pkg::CP_W-1-lud_pkg::CONT_BITS:0],
                     b[lud_pkg::CONT_BITS-1:0]};
        remaining = remaining - 1'b1;
        if (remaining == lud_pkg::FOLLOW_NONE) begin
          owe(acc, fin);
          return;
        end
      end
      if (fin) begin
        remaining = lud_pkg::FOLLOW_NONE;
        owe(acc, 1'b1);
      end
    endfunction

    task match_point(lud_pkg::cp_t cp, logic last);
      point_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected code point %06h last_point %0b", cp, last));
        return;
      end
      want = owed.pop_front();
      if (cp !== want.code_point)
        report($sformatf("code_point %06h, expected %06h", cp, want.code_point));
      if (last !== want.last_point)
        report($sformatf("last_point %0b, expected %0b (code_point %06h)",
                         last, want.last_point, want.code_point));
    endtask

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  localparam int RANDOM_BYTES = 800;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_LIMIT  = 20000;

  logic clk;
  logic rst;

  lud_byte_if stream_bus ();
  lud_cp_if   point_bus ();

  lenient_utf8_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_bus),
    .points (point_bus)
  );

  point_predictor predictor;
  int             bytes_taken = 0;

  // The calm flag turns off all idling on both sides for a stretch of the
  // random phase, so the block also runs at full rate for a while.
  bit calm          = 1'b0;
  bit long_hold_req = 1'b0;

  // Directed bytes, written as {string_end, in_byte}. They cover the ASCII
  // extremes, the bad lead bytes at both edges of their ranges, the smallest
  // two-byte and largest three-byte payloads, both four-byte extremes
  // (overlong and out-of-range values pass straight through), a lead pattern
  // sitting in a continuation slot, a truncated sequence, a lead byte that
  // ends its string at once, and single-byte results that end a string.
  logic [8:0] directed[$] = '{
    9'h000, 9'h07F, 9'h080, 9'h0BF, 9'h0F8, 9'h0FF,
    9'h0C0, 9'h080,
    9'h0EF, 9'h0BF, 9'h0BF,
    9'h0F0, 9'h080, 9'h080, 9'h080,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
    9'h0C3, 9'h0F5,
    9'h0E2, 9'h182,
    9'h1F4,
    9'h141,
    9'h1FE
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net: the slowest legal run is well under a tenth of this.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (calm)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one beat on the byte channel and hold it until the block takes it.
  // With no gap, valid simply stays high and only the payload changes.
  task automatic send_byte(lud_pkg::byte_t b, logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      stream_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    stream_bus.valid      <= 1'b1;
    stream_bus.in_byte    <= b;
    stream_bus.string_end <= fin;
    do @(posedge clk); while (!stream_bus.ready);
    predictor.take_byte(b, fin);
    bytes_taken++;
  endtask

  // One random sequence. Most are well-formed UTF-8 forms with random payload;
  // the rest are bad lead bytes, raw noise, continuation slots filled with
  // arbitrary bytes, and sequences cut short (usually by the end flag, now
  // and then silently so the next lead byte lands in a continuation slot).
  task automatic send_random_sequence();
    lud_pkg::byte_t seq[$];
    lud_pkg::byte_t lead;
    int             kind;
    int             follow;
    int             cut;
    bit             fin;
    follow = 0;
    kind   = $urandom_range(0, 99);
    if (kind < 20) begin
      lead = lud_pkg::byte_t'($urandom_range(0, 127));
    end else if (kind < 45) begin
      lead   = 8'hC0 | lud_pkg::byte_t'($urandom_range(0, 31));
      follow = 1;
    end else if (kind < 68) begin
      lead   = 8'hE0 | lud_pkg::byte_t'($urandom_range(0, 15));
      follow = 2;
    end else if (kind < 86) begin
      lead   = 8'hF0 | lud_pkg::byte_t'($urandom_range(0, 7));
      follow = 3;
    end else if (kind < 93) begin
      lead = $urandom_range(0, 1) ? (8'h80 | lud_pkg::byte_t'($urandom_range(0, 63)))
                                  : (8'hF8 | lud_pkg::byte_t'($urandom_range(0, 7)));
    end else begin
      lead = lud_pkg::byte_t'($urandom);
    end
    seq.insert(seq.size(), lead);
    repeat (follow) begin
      if ($urandom_range(0, 9) == 0)
        seq.insert(seq.size(), lud_pkg::byte_t'($urandom));
      else
        seq.insert(seq.size(), 8'h80 | lud_pkg::byte_t'($urandom_range(0, 63)));
    end

    cut = seq.size();
    fin = ($urandom_range(0, 5) == 0);
    if (follow > 0 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, follow);
      fin = ($urandom_range(0, 9) < 7);
    end
    for (int i = 0; i < cut; i++)
      send_byte(seq[i], fin && (i == cut - 1));
  endtask

  // Receiver. Ready is decided once per cycle. A long hold-off requested by
  // the stimulus is counted out here while the sender keeps offering bytes,
  // so the output register fills and the block has to stall its input.
  initial begin
    int hold;
    hold            = 0;
    point_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (hold == 0) begin
        hold = pick_gap();
      end
      point_bus.ready <= (hold == 0);
      if (hold > 0)
        hold--;
    end
  end

  // Every beat on the point channel is checked against the oldest code point
  // still owed.
  always @(posedge clk) begin
    if (!rst && point_bus.valid && point_bus.ready)
      predictor.match_point(point_bus.code_point, point_bus.last_point);
  end

  initial begin
    bit hold_asked;
    int drain;
    predictor             = new();
    hold_asked            = 1'b0;
    rst                   = 1'b1;
    stream_bus.valid      = 1'b0;
    stream_bus.in_byte    = '0;
    stream_bus.string_end = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_byte(directed[i][7:0], directed[i][8]);

    // Random phase. The long hold-off goes in once, early on, and a calm
    // stretch with no idling follows later.
    while (bytes_taken < directed.size() + RANDOM_BYTES) begin
      if (!hold_asked && bytes_taken >= 300) begin
        long_hold_req = 1'b1;
        hold_asked    = 1'b1;
      end
      calm = (bytes_taken >= 550 && bytes_taken < 650);
      send_random_sequence();
    end
    @(negedge clk);
    stream_bus.valid <= 1'b0;

    // Let the owed code points drain, then keep the clock running so that a
    // stray beat would show up.
    drain = 0;
    while (predictor.outstanding() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (predictor.outstanding() != 0)
      predictor.report($sformatf("%0d code points never arrived",
                                 predictor.outstanding()));

    if (predictor.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
